@@ design/ledaof_pkg.sv @@
`timescale 1ns / 1ps

package ledaof_pkg;

    localparam int DUTY_BITS = 8;
    localparam int TICK_BITS = 64;
    localparam int MS_BITS   = 32;
    localparam int CFG_BITS  = 32;
    localparam int CFG_IDX_BITS = 3;
    // Fade numerator: level (DUTY_BITS) times a 32-bit ms count.
    localparam int NUM_BITS  = DUTY_BITS + MS_BITS;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_ON    = 2'd1,
        REQ_OFF   = 2'd2,
        REQ_FLASH = 2'd3
    } t_req;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_OFF   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL_ON    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AUTO_OFF    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ON_TICKS    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_MS     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FLASH_TICKS = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOCKED      = 3'd6;

    localparam logic [DUTY_BITS-1:0] LEVEL_ON_RESET = '1;

    typedef struct packed {
        t_req                 req_type;
        logic [TICK_BITS-1:0] tick_now;
        logic [MS_BITS-1:0]   ms_now;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty;
        logic                 duty_written;
        logic                 is_on;
        logic                 is_off;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic switch_on;
        logic switch_off;
        logic flash;
        logic clr_flash;
        logic start_fade;
        logic mul_a;
        logic mul_b;
        logic div_start;
        logic fade_write;
        logic result;
    } t_dp_cmd;

    typedef struct packed {
        t_req req;
        logic locked;
        logic flash_flag;
        logic flash_active;
        logic arm_hit;
        logic fade_nonzero;
        logic fading;
        logic elapsed_ge;
        logic div_busy;
        logic out_free;
    } t_dp_stat;

endpackage

@@ design/ledaof_div.sv @@
`timescale 1ns / 1ps

module ledaof_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ledaof_pkg::NUM_BITS-1:0] i_num,
    input  logic [ledaof_pkg::MS_BITS-1:0]  i_den,
    output logic                            o_busy,
    output logic [ledaof_pkg::DUTY_BITS-1:0] o_quot
);
    import ledaof_pkg::*;

    localparam int CNT_W = (DUTY_BITS > 1) ? $clog2(DUTY_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DUTY_BITS - 1);

    logic [MS_BITS-1:0]   r_rem;
    logic [DUTY_BITS-1:0] r_quo;
    logic [MS_BITS-1:0]   r_den;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;

    logic [MS_BITS:0] trial;
    logic [MS_BITS:0] diff;
    logic             ge;

    // The quotient is known to fit in DUTY_BITS, so the upper part of the
    // numerator is already below the divisor and only DUTY_BITS steps remain.
    assign trial = {r_rem, r_quo[DUTY_BITS-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NUM_BITS-1:DUTY_BITS];
            r_quo <= i_num[DUTY_BITS-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[MS_BITS-1:0] : trial[MS_BITS-1:0];
            r_quo <= {r_quo[DUTY_BITS-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

@@ design/ledaof_dp.sv @@
`timescale 1ns / 1ps

module ledaof_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ledaof_pkg::t_in_item                i_in_data,
    input  logic                                i_cfg_valid,
    input  logic [ledaof_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [ledaof_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  logic                                i_out_stall,
    input  ledaof_pkg::t_dp_cmd                 i_cmd,
    output ledaof_pkg::t_dp_stat                o_stat,
    output logic                                o_out_valid,
    output ledaof_pkg::t_out_item               o_out_data
);
    import ledaof_pkg::*;

    // Configuration
    logic [DUTY_BITS-1:0] r_level_off;
    logic [DUTY_BITS-1:0] r_level_on;
    logic                 r_auto_off;
    logic [CFG_BITS-1:0]  r_on_ticks;
    logic [MS_BITS-1:0]   r_fade_ms;
    logic [CFG_BITS-1:0]  r_flash_ticks;
    logic                 r_locked;

    // Controller state
    logic [DUTY_BITS-1:0] r_logical;
    logic [DUTY_BITS-1:0] r_drive;
    logic                 r_lit;
    logic                 r_fading;
    logic                 r_flash;
    logic [TICK_BITS-1:0] r_flash_start;
    logic [TICK_BITS-1:0] r_off_tick;
    logic [MS_BITS-1:0]   r_fade_start;
    logic [DUTY_BITS-1:0] r_fade_from;
    logic                 r_wrote;

    // Current item and fade arithmetic
    t_in_item             r_in;
    logic [NUM_BITS-1:0]  r_p0;
    logic [NUM_BITS-1:0]  r_p1;
    logic [MS_BITS-1:0]   r_rest;

    logic                 r_out_valid;
    t_out_item            r_out;

    logic [TICK_BITS-1:0] flash_age;
    logic [MS_BITS-1:0]   elapsed;
    logic [NUM_BITS-1:0]  p0_n;
    logic [NUM_BITS-1:0]  p1_n;
    logic [NUM_BITS-1:0]  num_sum;
    logic                 div_busy;
    logic [DUTY_BITS-1:0] quot;
    logic                 out_free;

    assign flash_age = r_in.tick_now - r_flash_start;
    assign elapsed   = r_in.ms_now - r_fade_start;
    assign p0_n      = NUM_BITS'(r_level_off) * NUM_BITS'(elapsed);
    assign p1_n      = NUM_BITS'(r_fade_from) * NUM_BITS'(r_rest);
    // The weighted sum never exceeds the full level times the fade length.
    assign num_sum   = r_p0 + r_p1;
    assign out_free  = !r_out_valid || !i_out_stall;

    ledaof_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num_sum),
        .i_den   (r_fade_ms),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    always_comb begin
        o_stat.req          = r_in.req_type;
        o_stat.locked       = r_locked;
        o_stat.flash_flag   = r_flash;
        o_stat.flash_active = flash_age < TICK_BITS'(r_flash_ticks);
        o_stat.arm_hit      = r_auto_off && r_lit && !r_fading
                              && (r_in.tick_now >= r_off_tick);
        o_stat.fade_nonzero = r_fade_ms != '0;
        o_stat.fading       = r_fading;
        o_stat.elapsed_ge   = elapsed >= r_fade_ms;
        o_stat.div_busy     = div_busy;
        o_stat.out_free     = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_off   <= '0;
            r_level_on    <= LEVEL_ON_RESET;
            r_auto_off    <= 1'b0;
            r_on_ticks    <= '0;
            r_fade_ms     <= '0;
            r_flash_ticks <= '0;
            r_locked      <= 1'b0;
            r_logical     <= '0;
            r_drive       <= '0;
            r_lit         <= 1'b0;
            r_fading      <= 1'b0;
            r_flash       <= 1'b0;
            r_flash_start <= '0;
            r_off_tick    <= '0;
            r_fade_start  <= '0;
            r_fade_from   <= '0;
            r_wrote       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LEVEL_OFF:   r_level_off   <= i_cfg_data[DUTY_BITS-1:0];
                    CFG_LEVEL_ON:    r_level_on    <= i_cfg_data[DUTY_BITS-1:0];
                    CFG_AUTO_OFF:    r_auto_off    <= i_cfg_data[0];
                    CFG_ON_TICKS:    r_on_ticks    <= i_cfg_data;
                    CFG_FADE_MS:     r_fade_ms     <= i_cfg_data[MS_BITS-1:0];
                    CFG_FLASH_TICKS: r_flash_ticks <= i_cfg_data;
                    CFG_LOCKED:      r_locked      <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_cmd.load) begin
                r_wrote <= 1'b0;
            end
            if (i_cmd.switch_on) begin
                r_logical <= r_level_on;
                r_drive   <= r_level_on;
                r_wrote   <= 1'b1;
                r_lit     <= 1'b1;
                if (r_auto_off) begin
                    r_off_tick <= r_in.tick_now + TICK_BITS'(r_on_ticks);
                end
            end
            if (i_cmd.switch_off) begin
                r_logical <= r_level_off;
                r_drive   <= r_level_off;
                r_wrote   <= 1'b1;
                r_lit     <= 1'b0;
                r_fading  <= 1'b0;
            end
            if (i_cmd.flash) begin
                r_flash       <= 1'b1;
                r_flash_start <= r_in.tick_now;
                r_drive       <= r_level_on;
                r_wrote       <= 1'b1;
            end
            if (i_cmd.clr_flash) begin
                r_flash <= 1'b0;
            end
            if (i_cmd.start_fade) begin
                r_fading     <= 1'b1;
                r_fade_start <= r_in.ms_now;
                r_fade_from  <= r_logical;
            end
            if (i_cmd.fade_write) begin
                r_logical <= quot;
                r_drive   <= quot;
                r_wrote   <= 1'b1;
            end

            if (i_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.mul_a) begin
            r_p0   <= p0_n;
            r_rest <= r_fade_ms - elapsed;
        end
        if (i_cmd.mul_b) begin
            r_p1 <= p1_n;
        end
        if (i_cmd.result) begin
            r_out.duty         <= r_drive;
            r_out.duty_written <= r_wrote;
            r_out.is_on        <= r_logical == r_level_on;
            r_out.is_off       <= r_logical == r_level_off;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // A fade only ever runs on a lit LED.
    a_fade_implies_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fading |-> r_lit)
        else $error("fading flag set while the LED is not lit");
`endif

endmodule

@@ design/ledaof_ctrl.sv @@
`timescale 1ns / 1ps

module ledaof_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ledaof_pkg::t_dp_stat i_stat,
    output ledaof_pkg::t_dp_cmd  o_cmd
);
    import ledaof_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DECODE = 9'b000000010,
        ST_FLASH  = 9'b000000100,
        ST_ARM    = 9'b000001000,
        ST_FADE   = 9'b000010000,
        ST_MUL    = 9'b000100000,
        ST_ADD    = 9'b001000000,
        ST_DIV    = 9'b010000000,
        ST_RESULT = 9'b100000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_stat.req)
                    REQ_TICK: begin
                        n_state = ST_FLASH;
                    end
                    REQ_ON: begin
                        cmd.switch_on = !i_stat.locked;
                        n_state       = ST_RESULT;
                    end
                    REQ_OFF: begin
                        cmd.switch_off = !i_stat.locked;
                        n_state        = ST_RESULT;
                    end
                    REQ_FLASH: begin
                        cmd.flash = 1'b1;
                        n_state   = ST_RESULT;
                    end
                    default: n_state = ST_RESULT;
                endcase
            end
            ST_FLASH: begin
                // A tick inside the flash window is swallowed; the first one
                // past it ends the flash even when the block is locked.
                if (i_stat.flash_flag && i_stat.flash_active) begin
                    n_state = ST_RESULT;
                end else begin
                    cmd.clr_flash = i_stat.flash_flag;
                    n_state       = i_stat.locked ? ST_RESULT : ST_ARM;
                end
            end
            ST_ARM: begin
                if (i_stat.arm_hit) begin
                    if (i_stat.fade_nonzero) begin
                        cmd.start_fade = 1'b1;
                        n_state        = ST_FADE;
                    end else begin
                        cmd.switch_off = 1'b1;
                        n_state        = ST_RESULT;
                    end
                end else if (i_stat.fading) begin
                    n_state = ST_FADE;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_FADE: begin
                if (i_stat.elapsed_ge) begin
                    cmd.switch_off = 1'b1;
                    n_state        = ST_RESULT;
                end else begin
                    cmd.mul_a = 1'b1;
                    n_state   = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_b = 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                cmd.div_start = 1'b1;
                n_state       = ST_DIV;
            end
            ST_DIV: begin
                if (!i_stat.div_busy) begin
                    cmd.fade_write = 1'b1;
                    n_state        = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    cmd.result = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_cmd      = cmd;

`ifndef SYNTHESIS
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_state == ST_DECODE)
        else $error("accepted beat was not decoded next");

    a_fade_needs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FADE |-> i_stat.fading)
        else $error("fade step entered without an active fade");

    a_div_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ADD |=> r_state == ST_DIV && i_stat.div_busy)
        else $error("divider did not start for the fade step");
`endif

endmodule

@@ design/led_auto_off_fade_controller.sv @@
`timescale 1ns / 1ps

// LED auto-off fade controller: each accepted beat (tick, turn_on, turn_off
// or flash) yields exactly one result beat with the driven duty, a written
// flag and the on/off status of the logical level. Turn_on, turn_off and
// flash beats pass the decode and result states before the next beat is
// taken; a tick also passes the flash check and may pass the auto-off
// check; a fade step adds the two multiplications and the 8-step restoring
// divider that forms the fade level. A finished result sits in an output
// register, so the next beat is accepted while it waits. Configuration
// writes are always ready and must be issued while no beat is in flight.
module led_auto_off_fade_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ledaof_pkg::t_in_item                i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ledaof_pkg::t_out_item               o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ledaof_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [ledaof_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import ledaof_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    ledaof_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ledaof_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
